// ----- design/tpq_pkg.sv -----
// tpq_pkg: shared types, register codes and reset values for the touch press qualifier
// used by every module of the block; depends on nothing

package tpq_pkg;

	// default widths of the sample and tick paths
	localparam int TPQ_SAMPLE_BITS = 12;
	localparam int TPQ_TICK_BITS = 4;

	// register file layout
	localparam int CFG_LEVEL_BITS = 12;
	localparam int CFG_HOLD_BITS = 4;
	localparam int CFG_DATA_BITS = 12;
	localparam int CFG_INDEX_BITS = 3;

	// register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PRESS_THRESHOLD = 3'd0,
		REG_STABILITY_LIMIT = 3'd1,
		REG_Y_MINIMUM = 3'd2,
		REG_DOWN_HOLD_TICKS = 3'd3,
		REG_UP_HOLD_TICKS = 3'd4
	} cfg_reg_t;

	// register reset values
	localparam logic [CFG_LEVEL_BITS-1:0] RST_PRESS_THRESHOLD = 12'd100;
	localparam logic [CFG_LEVEL_BITS-1:0] RST_STABILITY_LIMIT = 12'd20;
	localparam logic [CFG_LEVEL_BITS-1:0] RST_Y_MINIMUM = 12'd400;
	localparam logic [CFG_HOLD_BITS-1:0] RST_DOWN_HOLD_TICKS = 4'd4;
	localparam logic [CFG_HOLD_BITS-1:0] RST_UP_HOLD_TICKS = 4'd10;

	// press/release machine states
	typedef enum logic [1:0] {
		ST_RELEASED = 2'd0,
		ST_RELEASING = 2'd1,
		ST_PRESSING = 2'd2,
		ST_PRESSED = 2'd3
	} press_state_t;

	// current register contents
	typedef struct packed {
		logic [CFG_LEVEL_BITS-1:0] press_threshold;
		logic [CFG_LEVEL_BITS-1:0] stability_limit;
		logic [CFG_LEVEL_BITS-1:0] y_minimum;
		logic [CFG_HOLD_BITS-1:0] down_hold_ticks;
		logic [CFG_HOLD_BITS-1:0] up_hold_ticks;
	} cfg_t;

	// one-shot events of one item
	typedef struct packed {
		logic press_start;
		logic press_hold;
		logic release_start;
		logic release_hold;
	} events_t;

endpackage

// ----- design/tpq_cfg_regs.sv -----
// tpq_cfg_regs: configuration registers of the touch press qualifier
// depends on tpq_pkg

module tpq_cfg_regs
	import tpq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_threshold <= RST_PRESS_THRESHOLD;
			cfg_q.stability_limit <= RST_STABILITY_LIMIT;
			cfg_q.y_minimum <= RST_Y_MINIMUM;
			cfg_q.down_hold_ticks <= RST_DOWN_HOLD_TICKS;
			cfg_q.up_hold_ticks <= RST_UP_HOLD_TICKS;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PRESS_THRESHOLD: cfg_q.press_threshold <= cfg_data[CFG_LEVEL_BITS-1:0];
				REG_STABILITY_LIMIT: cfg_q.stability_limit <= cfg_data[CFG_LEVEL_BITS-1:0];
				REG_Y_MINIMUM: cfg_q.y_minimum <= cfg_data[CFG_LEVEL_BITS-1:0];
				REG_DOWN_HOLD_TICKS: cfg_q.down_hold_ticks <= cfg_data[CFG_HOLD_BITS-1:0];
				REG_UP_HOLD_TICKS: cfg_q.up_hold_ticks <= cfg_data[CFG_HOLD_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/tpq_core.sv -----
// tpq_core: press qualification, press/release state machine and hold counters
// depends on tpq_pkg; steps once for every item that moves to the result register

module tpq_core
	import tpq_pkg::*;
#(
	parameter int SAMPLE_BITS = TPQ_SAMPLE_BITS,
	parameter int TICK_BITS = TPQ_TICK_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  cfg_t cfg,
	input  logic [SAMPLE_BITS-1:0] x1,
	input  logic [SAMPLE_BITS-1:0] x2,
	input  logic [SAMPLE_BITS-1:0] y,
	output logic report_valid,
	output logic [SAMPLE_BITS-1:0] raw_x,
	output logic [SAMPLE_BITS-1:0] raw_y,
	output logic [1:0] touch_state,
	output logic [TICK_BITS-1:0] hold_time,
	output events_t events
);

	localparam int LIM_W = (TICK_BITS > CFG_HOLD_BITS) ? TICK_BITS : CFG_HOLD_BITS;
	localparam logic [LIM_W-1:0] TICK_MAX_W = LIM_W'({TICK_BITS{1'b1}});

	press_state_t state_q, state_d;
	logic [TICK_BITS-1:0] press_ticks_q, press_ticks_d;
	logic [TICK_BITS-1:0] release_ticks_q, release_ticks_d;
	logic ph_armed_q, ph_armed_d;
	logic rs_armed_q, rs_armed_d;
	logic rh_armed_q, rh_armed_d;

	logic [SAMPLE_BITS-1:0] diff;
	logic is_press, is_valid;
	logic [LIM_W-1:0] down_lim_w, up_lim_w;
	logic [TICK_BITS-1:0] down_lim, up_lim;
	logic down_open, up_open, was_down;

	// qualification of the sampling pass
	always_comb begin
		diff = (x1 >= x2) ? (x1 - x2) : (x2 - x1);
		is_press = x1 > SAMPLE_BITS'(cfg.press_threshold);
		is_valid = is_press && (diff < SAMPLE_BITS'(cfg.stability_limit))
			&& (y > SAMPLE_BITS'(cfg.y_minimum));
	end

	// hold limits clipped to the counter range
	always_comb begin
		down_lim_w = LIM_W'(cfg.down_hold_ticks);
		up_lim_w = LIM_W'(cfg.up_hold_ticks);
		down_lim = (down_lim_w > TICK_MAX_W) ? TICK_BITS'(TICK_MAX_W) : TICK_BITS'(down_lim_w);
		up_lim = (up_lim_w > TICK_MAX_W) ? TICK_BITS'(TICK_MAX_W) : TICK_BITS'(up_lim_w);
		down_open = press_ticks_q < down_lim;
		up_open = release_ticks_q < up_lim;
		was_down = (state_q == ST_PRESSING) || (state_q == ST_PRESSED);
	end

	// next state and counters
	always_comb begin
		state_d = state_q;
		press_ticks_d = press_ticks_q;
		release_ticks_d = release_ticks_q;
		ph_armed_d = ph_armed_q;
		rs_armed_d = rs_armed_q;
		rh_armed_d = rh_armed_q;
		if (is_valid) begin
			if (was_down) begin
				state_d = ST_PRESSED;
				if (down_open) begin
					press_ticks_d = press_ticks_q + TICK_BITS'(1);
				end else begin
					ph_armed_d = 1'b0;
				end
			end else begin
				state_d = ST_PRESSING;
				press_ticks_d = '0;
				ph_armed_d = 1'b1;
				rs_armed_d = 1'b1;
			end
		end else if (!is_press) begin
			if (was_down) begin
				state_d = ST_RELEASING;
				release_ticks_d = '0;
				rs_armed_d = 1'b0;
				rh_armed_d = 1'b1;
			end else begin
				state_d = ST_RELEASED;
				if (up_open) begin
					release_ticks_d = release_ticks_q + TICK_BITS'(1);
				end else begin
					rh_armed_d = 1'b0;
				end
			end
		end
	end

	// result fields and events
	always_comb begin
		report_valid = is_valid;
		raw_x = is_valid ? x2 : '0;
		raw_y = is_valid ? y : '0;
		touch_state = state_d;
		hold_time = (state_d == ST_PRESSED) ? press_ticks_d : '0;
		events.press_start = is_valid && !was_down;
		events.press_hold = is_valid && was_down && !down_open && ph_armed_q;
		events.release_start = !is_press && was_down && rs_armed_q;
		events.release_hold = !is_press && !was_down && !up_open && rh_armed_q;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RELEASED;
			press_ticks_q <= '0;
			release_ticks_q <= '0;
			ph_armed_q <= 1'b0;
			rs_armed_q <= 1'b0;
			rh_armed_q <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			press_ticks_q <= press_ticks_d;
			release_ticks_q <= release_ticks_d;
			ph_armed_q <= ph_armed_d;
			rs_armed_q <= rs_armed_d;
			rh_armed_q <= rh_armed_d;
		end
	end

endmodule

// ----- design/touch_press_qualifier.sv -----
// touch_press_qualifier: top level, input register, result register and glue
// depends on tpq_pkg, tpq_cfg_regs and tpq_core
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | first_x_sample, second_x_sample, y_sample
//  out     | out_valid / out_stall| report_valid, raw_x, raw_y, touch_state,
//          |                      | hold_time, four event flags
//  cfg     | cfg_write            | cfg_index, cfg_data
//
// every item gives one result; it passes from the input register to the result register,
// where out_valid rises, and out_stall can hold it in either register on the way
// one item per cycle is sustained while out_stall is low: the state update sits between
// the input register and the result register
// reset returns the state machine to released and the config registers to their defaults
// a stalled result holds while one more item waits in the input register

module touch_press_qualifier
	import tpq_pkg::*;
#(
	parameter int SAMPLE_BITS = TPQ_SAMPLE_BITS,
	parameter int TICK_BITS = TPQ_TICK_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [SAMPLE_BITS-1:0] first_x_sample,
	input  logic [SAMPLE_BITS-1:0] second_x_sample,
	input  logic [SAMPLE_BITS-1:0] y_sample,
	output logic out_valid,
	input  logic out_stall,
	output logic report_valid,
	output logic [SAMPLE_BITS-1:0] raw_x,
	output logic [SAMPLE_BITS-1:0] raw_y,
	output logic [1:0] touch_state,
	output logic [TICK_BITS-1:0] hold_time,
	output logic press_start_event,
	output logic press_hold_event,
	output logic release_start_event,
	output logic release_hold_event
);

	cfg_t cfg;

	logic valid_s1;
	logic [SAMPLE_BITS-1:0] x1_s1, x2_s1, y_s1;

	logic valid_s2;
	logic report_valid_s2;
	logic [SAMPLE_BITS-1:0] raw_x_s2, raw_y_s2;
	logic [1:0] touch_state_s2;
	logic [TICK_BITS-1:0] hold_time_s2;
	events_t events_s2;

	logic load_s2, step;
	logic core_valid;
	logic [SAMPLE_BITS-1:0] core_raw_x, core_raw_y;
	logic [1:0] core_state;
	logic [TICK_BITS-1:0] core_hold;
	events_t core_events;

	tpq_cfg_regs u_cfg_regs (
		.clk (clk),
		.arst_n (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data (cfg_data),
		.cfg (cfg)
	);

	// flow control between the two registers
	assign load_s2 = !valid_s2 || !out_stall;
	assign step = valid_s1 && load_s2;
	assign in_stall = valid_s1 && !load_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			x1_s1 <= first_x_sample;
			x2_s1 <= second_x_sample;
			y_s1 <= y_sample;
		end
	end

	tpq_core #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.TICK_BITS (TICK_BITS)
	) u_core (
		.clk (clk),
		.arst_n (arst_n),
		.step (step),
		.cfg (cfg),
		.x1 (x1_s1),
		.x2 (x2_s1),
		.y (y_s1),
		.report_valid (core_valid),
		.raw_x (core_raw_x),
		.raw_y (core_raw_y),
		.touch_state (core_state),
		.hold_time (core_hold),
		.events (core_events)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			report_valid_s2 <= core_valid;
			raw_x_s2 <= core_raw_x;
			raw_y_s2 <= core_raw_y;
			touch_state_s2 <= core_state;
			hold_time_s2 <= core_hold;
			events_s2 <= core_events;
		end
	end

	assign out_valid = valid_s2;
	assign report_valid = report_valid_s2;
	assign raw_x = raw_x_s2;
	assign raw_y = raw_y_s2;
	assign touch_state = touch_state_s2;
	assign hold_time = hold_time_s2;
	assign press_start_event = events_s2.press_start;
	assign press_hold_event = events_s2.press_hold;
	assign release_start_event = events_s2.release_start;
	assign release_hold_event = events_s2.release_hold;

endmodule

// ----- design/tpq_checker.sv -----
// tpq_checker: port-level checks on the result channel of the touch press qualifier
// depends on tpq_pkg; bound to touch_press_qualifier at the end of this file

module tpq_checker
	import tpq_pkg::*;
#(
	parameter int SAMPLE_BITS = TPQ_SAMPLE_BITS,
	parameter int TICK_BITS = TPQ_TICK_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic report_valid,
	input logic [SAMPLE_BITS-1:0] raw_x,
	input logic [SAMPLE_BITS-1:0] raw_y,
	input logic [1:0] touch_state,
	input logic [TICK_BITS-1:0] hold_time,
	input logic press_start_event,
	input logic press_hold_event,
	input logic release_start_event,
	input logic release_hold_event
);

	// stalled item holds its coordinates, touch state and hold time
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(raw_x) && $stable(raw_y)
			&& $stable(touch_state) && $stable(hold_time))
		else $error("stalled result changed");

	// a rejected or absent press carries no coordinates and no press events
	a_no_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !report_valid |-> raw_x == '0 && raw_y == '0
			&& !press_start_event && !press_hold_event)
		else $error("press data without a valid report");

	// a valid press never raises release events
	a_press_no_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report_valid |-> !release_start_event && !release_hold_event)
		else $error("release event on a valid press");

	// press start lands in pressing with zero hold time
	a_press_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && press_start_event |-> touch_state == ST_PRESSING
			&& report_valid && hold_time == '0)
		else $error("press start outside pressing");

endmodule

bind touch_press_qualifier tpq_checker #(
	.SAMPLE_BITS (SAMPLE_BITS),
	.TICK_BITS (TICK_BITS)
) u_tpq_checker (
	.clk (clk),
	.arst_n (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.report_valid (report_valid),
	.raw_x (raw_x),
	.raw_y (raw_y),
	.touch_state (touch_state),
	.hold_time (hold_time),
	.press_start_event (press_start_event),
	.press_hold_event (press_hold_event),
	.release_start_event (release_start_event),
	.release_hold_event (release_hold_event)
);
